[rtl/core/rau_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rau_pkg: shared types and codes of the rational arithmetic unit
// Item structs, command codes, status codes and the controller-to-datapath
// command and status groups.
// ---------------------------------------------------------------------------
package rau_pkg;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic [1:0]         status;
    } out_item_t;

    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_MUL    = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_INVALID  = 2'd3;

    typedef logic [3:0] op_t;

    localparam op_t OP_NONE      = 4'd0;
    localparam op_t OP_MUL0      = 4'd1;
    localparam op_t OP_MUL1      = 4'd2;
    localparam op_t OP_MUL2      = 4'd3;
    localparam op_t OP_SUM       = 4'd4;
    localparam op_t OP_GCD       = 4'd5;
    localparam op_t OP_DIVA_INIT = 4'd6;
    localparam op_t OP_DIV_STEP  = 4'd7;
    localparam op_t OP_DIVB_INIT = 4'd8;
    localparam op_t OP_FINISH    = 4'd9;

    typedef struct packed {
        logic load;
        op_t  op;
    } dp_cmd_t;

    typedef struct packed {
        logic invalid;
        logic create;
        logic zero_mag;
        logic gcd_done;
        logic div_done;
    } dp_status_t;

endpackage

[rtl/core/rau_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rau_ctrl: sequencer of the rational arithmetic unit
// Walks one item through products (add and multiply only), sum, GCD and
// two divisions, and owns the input ready and output valid of the block.
// ---------------------------------------------------------------------------
module rau_ctrl
    import rau_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t dp_status,
    output dp_cmd_t    dp_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLASS  = 4'd1;
    localparam logic [3:0] S_MUL0   = 4'd2;
    localparam logic [3:0] S_MUL1   = 4'd3;
    localparam logic [3:0] S_MUL2   = 4'd4;
    localparam logic [3:0] S_SUM    = 4'd5;
    localparam logic [3:0] S_GCD    = 4'd6;
    localparam logic [3:0] S_DIVA_I = 4'd7;
    localparam logic [3:0] S_DIVA   = 4'd8;
    localparam logic [3:0] S_DIVB_I = 4'd9;
    localparam logic [3:0] S_DIVB   = 4'd10;
    localparam logic [3:0] S_FINISH = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        dp_cmd.load    = 1'b0;
        dp_cmd.op      = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    dp_cmd.load = 1'b1;
                    state_next  = S_CLASS;
                end
            end
            S_CLASS:
            begin
                priority if (dp_status.invalid) state_next = S_FINISH;
                else if (dp_status.create)      state_next = S_SUM;
                else                            state_next = S_MUL0;
            end
            S_MUL0:
            begin
                dp_cmd.op  = OP_MUL0;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                dp_cmd.op  = OP_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                dp_cmd.op  = OP_MUL2;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                dp_cmd.op  = OP_SUM;
                state_next = S_GCD;
            end
            S_GCD:
            begin
                priority if (dp_status.zero_mag) state_next = S_FINISH;
                else if (dp_status.gcd_done)     state_next = S_DIVA_I;
                else                             dp_cmd.op  = OP_GCD;
            end
            S_DIVA_I:
            begin
                dp_cmd.op  = OP_DIVA_INIT;
                state_next = S_DIVA;
            end
            S_DIVA:
            begin
                if (dp_status.div_done) state_next = S_DIVB_I;
                else                    dp_cmd.op  = OP_DIV_STEP;
            end
            S_DIVB_I:
            begin
                dp_cmd.op  = OP_DIVB_INIT;
                state_next = S_DIVB;
            end
            S_DIVB:
            begin
                if (dp_status.div_done) state_next = S_FINISH;
                else                    dp_cmd.op  = OP_DIV_STEP;
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    dp_cmd.op      = OP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/core/rau_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rau_datapath: arithmetic of the rational arithmetic unit
// Shared 32x32 multiplier, sum and sign logic, binary GCD stepper,
// radix-2 restoring divider and the output register.
// ---------------------------------------------------------------------------
module rau_datapath
    import rau_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic       clk,
    input  in_item_t   in_data,
    input  dp_cmd_t    dp_cmd,
    output dp_status_t dp_status,
    output out_item_t  out_data
);

    localparam logic [63:0] LIM = (64'd1 << (WIDTH - 1)) - 64'd1;

    in_item_t           item_reg;
    logic               invalid_reg;
    logic signed [63:0] p0_reg, p1_reg;
    logic [63:0]        den_reg;
    logic [63:0]        mag_reg;
    logic               neg_reg;
    logic [1:0]         st_reg;
    logic [63:0]        u_reg, v_reg;
    logic [5:0]         k_reg;
    logic [63:0]        g_reg;
    logic [64:0]        rem_reg;
    logic [63:0]        quo_reg;
    logic [6:0]         cnt_reg;
    logic [63:0]        qa_reg;
    out_item_t          out_reg;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_res;
    logic signed [63:0] num_w, an_w, ad_w;
    logic [63:0]        den_w;
    logic [64:0]        trial;
    logic               fits;

    assign dp_status.invalid  = invalid_reg;
    assign dp_status.create   = (item_reg.command == CMD_CREATE);
    assign dp_status.zero_mag = (mag_reg == 64'd0);
    assign dp_status.gcd_done = (u_reg == 64'd0);
    assign dp_status.div_done = cnt_reg[6];
    assign out_data           = out_reg;

    always_comb
    begin
        unique case (dp_cmd.op)
            OP_MUL0:
            begin
                mul_a = item_reg.a_num;
                mul_b = (item_reg.command == CMD_ADD) ? item_reg.b_den : item_reg.b_num;
            end
            OP_MUL1:
            begin
                mul_a = item_reg.b_num;
                mul_b = item_reg.a_den;
            end
            default:
            begin
                mul_a = item_reg.a_den;
                mul_b = item_reg.b_den;
            end
        endcase
        mul_res = mul_a * mul_b;
    end

    always_comb
    begin
        an_w = 64'(item_reg.a_num);
        ad_w = 64'(item_reg.a_den);
        priority if (item_reg.command == CMD_CREATE)
        begin
            num_w = (ad_w < 0) ? -an_w : an_w;
            priority if (ad_w == 0) den_w = 64'd1;
            else if (ad_w < 0)      den_w = 64'(-ad_w);
            else                    den_w = 64'(ad_w);
        end
        else
        begin
            num_w = (item_reg.command == CMD_ADD) ? p0_reg + p1_reg : p0_reg;
            den_w = den_reg;
        end
    end

    assign trial = {rem_reg[63:0], quo_reg[63]};
    assign fits  = (quo_reg <= LIM) && (qa_reg <= LIM + {63'd0, neg_reg});

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            item_reg    <= in_data;
            invalid_reg <= (in_data.command != CMD_CREATE)
                && ((in_data.command != CMD_ADD && in_data.command != CMD_MUL)
                    || in_data.a_den <= 0 || in_data.b_den <= 0);
            mag_reg     <= 64'd0;
        end
        unique case (dp_cmd.op)
            OP_NONE: ;
            OP_MUL0: p0_reg  <= mul_res;
            OP_MUL1: p1_reg  <= mul_res;
            OP_MUL2: den_reg <= 64'(mul_res);
            OP_SUM:
            begin
                neg_reg <= num_w[63];
                mag_reg <= num_w[63] ? 64'(-num_w) : 64'(num_w);
                u_reg   <= num_w[63] ? 64'(-num_w) : 64'(num_w);
                v_reg   <= den_w;
                k_reg   <= 6'd0;
                st_reg  <= (item_reg.command == CMD_CREATE && item_reg.a_den == 0)
                           ? ST_ZERO_DEN : ST_OK;
            end
            OP_GCD:
            begin
                priority if (!u_reg[0] && !v_reg[0])
                begin
                    u_reg <= u_reg >> 1;
                    v_reg <= v_reg >> 1;
                    k_reg <= k_reg + 6'd1;
                end
                else if (!u_reg[0]) u_reg <= u_reg >> 1;
                else if (!v_reg[0]) v_reg <= v_reg >> 1;
                else if (u_reg >= v_reg) u_reg <= u_reg - v_reg;
                else v_reg <= v_reg - u_reg;
            end
            OP_DIVA_INIT:
            begin
                g_reg   <= v_reg << k_reg;
                rem_reg <= 65'd0;
                quo_reg <= mag_reg;
                cnt_reg <= 7'd0;
            end
            OP_DIV_STEP:
            begin
                if (trial >= {1'b0, g_reg})
                begin
                    rem_reg <= trial - {1'b0, g_reg};
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 7'd1;
            end
            OP_DIVB_INIT:
            begin
                qa_reg  <= quo_reg;
                rem_reg <= 65'd0;
                quo_reg <= den_w;
                cnt_reg <= 7'd0;
            end
            OP_FINISH:
            begin
                priority if (invalid_reg)
                begin
                    out_reg.res_num <= 32'sd0;
                    out_reg.res_den <= 31'd1;
                    out_reg.status  <= ST_INVALID;
                end
                else if (mag_reg == 64'd0)
                begin
                    out_reg.res_num <= 32'sd0;
                    out_reg.res_den <= 31'd1;
                    out_reg.status  <= st_reg;
                end
                else if (!fits)
                begin
                    out_reg.res_num <= 32'sd0;
                    out_reg.res_den <= 31'd1;
                    out_reg.status  <= ST_OVERFLOW;
                end
                else
                begin
                    out_reg.res_num <= neg_reg ? -qa_reg[31:0] : qa_reg[31:0];
                    out_reg.res_den <= quo_reg[30:0];
                    out_reg.status  <= st_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

[rtl/core/rational_arithmetic_unit_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rational_arithmetic_unit_core: exact fraction create, add and multiply
// Top level joining the sequencer and the datapath.
// ---------------------------------------------------------------------------
// One item at a time. Invalid operands go straight to the result, a create
// skips the products and a zero result skips the GCD and the divisions;
// otherwise the binary GCD stepper runs on the 64-bit numerator magnitude
// and denominator, and the one-bit-per-cycle divider is used twice, first
// for the numerator and then for the denominator. A result that finds the
// output register still full holds until it is taken. The result sits in
// an output register, so the block is ready for a new item once the result
// is registered, while that result waits. WIDTH sets only the range a
// result must fit; operands are always 32 bits.
module rational_arithmetic_unit_core
    import rau_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    rau_datapath #(.WIDTH(WIDTH)) u_datapath (
        .clk       (clk),
        .in_data   (in_data),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .out_data  (out_data)
    );

endmodule

[rtl/core/rau_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rau_checker: port-level checks of the rational arithmetic unit
// Concurrent assertions on the top-level ports, bound to the top level.
// ---------------------------------------------------------------------------
module rau_checker
    import rau_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output item changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while busy");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.res_den != 31'd0)
        else $error("zero denominator on output");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_OVERFLOW || out_data.status == ST_INVALID)
        |-> out_data.res_num == 32'sd0 && out_data.res_den == 31'd1)
        else $error("error item is not 0/1");

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

[test/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for rational_arithmetic_unit_core
// Drives create, add and multiply items on a valid/ready channel and checks
// each result against a behavioral fraction reducer or a typed-in result.
// ---------------------------------------------------------------------------
module testbench;
    import rau_pkg::*;

    localparam int WIDTH = 32;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    out_item_t fraction_q[$];
    int        mismatch_count;
    int        send_idle_pct;
    int        recv_idle_pct;

    typedef struct {
        in_item_t  item;
        bit        has_fixed;
        out_item_t fixed;
    } row_t;

    row_t rows[$];

    rational_arithmetic_unit_core #(.WIDTH(WIDTH)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic out_item_t lowest_terms(longint num, longint unsigned den,
                                               logic [1:0] st);
        out_item_t       r;
        bit              neg;
        longint unsigned mag;
        longint unsigned lim;
        longint unsigned g;
        neg = num < 0;
        mag = neg ? (64'd0 - longint'(num)) : num;
        lim = (64'd1 << (WIDTH - 1)) - 1;
        r.res_num = 0;
        r.res_den = 31'd1;
        r.status  = st;
        if (mag == 0)
            return r;
        g = euclid(mag, den);
        mag = mag / g;
        den = den / g;
        if (den > lim || mag > lim + (neg ? 1 : 0))
        begin
            r.status = ST_OVERFLOW;
            return r;
        end
        r.res_num = 32'(neg ? -longint'(mag) : longint'(mag));
        r.res_den = den[30:0];
        return r;
    endfunction

    function automatic out_item_t predict_fraction(in_item_t it);
        out_item_t r;
        longint    an;
        longint    ad;
        longint    bn;
        longint    bd;
        an = it.a_num;
        ad = it.a_den;
        bn = it.b_num;
        bd = it.b_den;
        if (it.command == CMD_CREATE)
        begin
            if (ad == 0)
                return lowest_terms(an, 1, ST_ZERO_DEN);
            if (ad < 0)
            begin
                an = -an;
                ad = -ad;
            end
            return lowest_terms(an, ad, ST_OK);
        end
        if (it.command != CMD_ADD && it.command != CMD_MUL || ad <= 0 || bd <= 0)
        begin
            r.res_num = 0;
            r.res_den = 31'd1;
            r.status  = ST_INVALID;
            return r;
        end
        if (it.command == CMD_ADD)
            return lowest_terms(an * bd + bn * ad, ad * bd, ST_OK);
        return lowest_terms(an * bn, ad * bd, ST_OK);
    endfunction

    function automatic in_item_t make_item(logic [1:0] c, int an, int ad, int bn, int bd);
        in_item_t it;
        it.command = c;
        it.a_num = an;
        it.a_den = ad;
        it.b_num = bn;
        it.b_den = bd;
        return it;
    endfunction

    function automatic out_item_t make_res(int n, int d, logic [1:0] st);
        out_item_t r;
        r.res_num = n;
        r.res_den = d[30:0];
        r.status  = st;
        return r;
    endfunction

    task automatic add_row(in_item_t it, bit fixed_ok, out_item_t fx);
        row_t rw;
        rw.item = it;
        rw.has_fixed = fixed_ok;
        rw.fixed = fx;
        rows.push_back(rw);
    endtask

    function automatic int rand_word(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 40) - 20;
            2: return $urandom_range(1, 1000);
            default: return $urandom_range(1, 65535) * ($urandom_range(0, 1) ? 1 : -1);
        endcase
    endfunction

    function automatic in_item_t random_item();
        in_item_t   it;
        int         m;
        logic [1:0] c;
        m = $urandom_range(0, 3);
        c = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        it = make_item(c, rand_word(m), rand_word(m), rand_word(m), rand_word(m));
        // mostly positive denominators so add/multiply get past the checks
        if (c != CMD_CREATE && $urandom_range(0, 9) != 0)
        begin
            it.a_den = it.a_den & 32'h7FFF_FFFF;
            it.b_den = it.b_den & 32'h7FFF_FFFF;
            if (it.a_den == 0) it.a_den = 1;
            if (it.b_den == 0) it.b_den = 1;
        end
        return it;
    endfunction

    // drop valid only while idling, so each step sees one assignment
    task automatic send_item(in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        fraction_q.push_back(predict_fraction(it));
    endtask

    // receiver side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (fraction_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result num=%0d den=%0d st=%0d",
                                 out_data.res_num, out_data.res_den, out_data.status);
                end
                else
                begin
                    out_item_t e;
                    e = fraction_q.pop_front();
                    if (e.res_num !== out_data.res_num || e.res_den !== out_data.res_den
                        || e.status !== out_data.status)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch exp %0d/%0d st=%0d got %0d/%0d st=%0d",
                                     e.res_num, e.res_den, e.status, out_data.res_num,
                                     out_data.res_den, out_data.status);
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #20_000_000;
        $display("rational_arithmetic_unit_core verification failed");
        $finish;
    end

    initial
    begin
        out_item_t nofix;
        int n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        mismatch_count = 0;
        send_idle_pct = 37;
        recv_idle_pct = 77;
        nofix = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(make_item(CMD_CREATE, 5, 0, 0, 0), 1, make_res(5, 1, ST_ZERO_DEN));
        add_row(make_item(CMD_CREATE, 0, 0, 0, 0), 1, make_res(0, 1, ST_ZERO_DEN));
        add_row(make_item(CMD_CREATE, 6, -4, 0, 0), 1, make_res(-3, 2, ST_OK));
        add_row(make_item(CMD_CREATE, 0, -7, 1, 1), 1, make_res(0, 1, ST_OK));
        add_row(make_item(CMD_CREATE, 32'sh8000_0000, -1, 0, 0), 1,
                make_res(0, 1, ST_OVERFLOW));
        add_row(make_item(CMD_CREATE, 32'sh8000_0000, 1, 0, 0), 1,
                make_res(32'sh8000_0000, 1, ST_OK));
        add_row(make_item(CMD_CREATE, 1, 32'sh8000_0000, 0, 0), 1,
                make_res(0, 1, ST_OVERFLOW));
        add_row(make_item(CMD_CREATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -1, -1), 1,
                make_res(1, 1, ST_OK));
        add_row(make_item(CMD_ADD, 1, 0, 1, 1), 1, make_res(0, 1, ST_INVALID));
        add_row(make_item(CMD_MUL, 1, 1, 1, -1), 1, make_res(0, 1, ST_INVALID));
        add_row(make_item(2'd3, 1, 1, 1, 1), 1, make_res(0, 1, ST_INVALID));
        add_row(make_item(2'd3, -1, -1, -1, -1), 1, make_res(0, 1, ST_INVALID));
        add_row(make_item(CMD_ADD, 1, 2, 1, 3), 0, nofix);
        add_row(make_item(CMD_ADD, 1, 2, -1, 2), 1, make_res(0, 1, ST_OK));
        add_row(make_item(CMD_MUL, 3, 4, 8, 9), 0, nofix);
        add_row(make_item(CMD_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1), 1,
                make_res(0, 1, ST_OVERFLOW));
        add_row(make_item(CMD_ADD, 32'sh8000_0000, 1, 32'sh8000_0000, 1), 1,
                make_res(0, 1, ST_OVERFLOW));
        add_row(make_item(CMD_MUL, 32'sh8000_0000, 1, 32'sh8000_0000, 1), 1,
                make_res(0, 1, ST_OVERFLOW));
        add_row(make_item(CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF), 1, make_res(1, 1, ST_OK));
        add_row(make_item(CMD_MUL, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF), 1,
                make_res(0, 1, ST_OVERFLOW));
        add_row(make_item(CMD_ADD, -1, 32'h7FFF_FFFF, 0, 3), 0, nofix);
        add_row(make_item(CMD_MUL, 0, 5, 32'sh8000_0000, 32'h7FFF_FFFF), 1,
                make_res(0, 1, ST_OK));

        foreach (rows[i])
        begin
            send_item(rows[i].item);
            // typed-in results override the predicted one for these rows
            if (rows[i].has_fixed)
                fraction_q[fraction_q.size() - 1] = rows[i].fixed;
        end
        in_valid <= 1'b0;

        // hold off until the directed results have drained
        while (fraction_q.size() != 0)
            @(posedge clk);

        for (n = 0; n < 900; n++)
        begin
            if (n == 300)
            begin
                send_idle_pct = 77;
                recv_idle_pct = 37;
            end
            if (n == 600)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_item(random_item());
        end
        in_valid <= 1'b0;

        while (fraction_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (mismatch_count == 0 && fraction_q.size() == 0)
            $display("rational_arithmetic_unit_core verification clean");
        else
            $display("rational_arithmetic_unit_core verification failed");
        $finish;
    end

endmodule
